>>> rtl/core/rxbf_pkg.sv
// ----------------------------------------------------------------------------
// rxbf_pkg
// Opcodes, control characters, register indexes and shared types of the
// receive byte FIFO with line read.
// ----------------------------------------------------------------------------
package rxbf_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_LINE  = 2'd2,
    OP_FLUSH = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_FLOW_ENABLE    = 2'd0,
    CFG_FILL_THRESHOLD = 2'd1,
    CFG_CTS_INVERTED   = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Most bytes a single read command takes.
  localparam logic [6:0] MAX_READ = 7'd64;

  localparam logic [6:0] FILL_THRESHOLD_RESET = 7'd48;

  typedef struct packed {
    logic       overflow;
    logic       cts_pin;
    logic [6:0] fill_count;
    logic       last;
    logic       data_valid;
    logic [7:0] data_out;
  } result_t;

endpackage

>>> rtl/core/rx_byte_fifo_with_line_read.sv
// ----------------------------------------------------------------------------
// rx_byte_fifo_with_line_read
// Receive ring FIFO of bytes with line read and clear-to-send flow control.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries commands: push a byte, read up to read_count
//   bytes, read a line (up to and including the first CR) or flush. Every
//   command gives one or more items on the out_ channel; the final one of a
//   command carries tlast. Each byte taken from the ring gives one item.
//   A push, a flush or a read that finds nothing gives a single item in
//   the cycle after acceptance. A read enters a drain state in the cycle
//   after acceptance and then emits one byte per cycle from the ring
//   memory unless out_tready stalls it; the drain rate is set by the single
//   read port of the byte store, whose next address is prefetched each
//   cycle. No new command is accepted while a read drains.
//   A push into a full ring is dropped and flagged as overflow.
//   The cfg_ port writes flow_enable, fill_threshold and cts_inverted; it is
//   always ready; the user must write it only while the block is idle, which the block does not enforce.
//   Reset empties the ring, raises ready-to-send and loads register defaults.
//   Ring contents are not cleared. When out_tready is low, the result item
//   holds in the output register and the sequencer waits.
// ----------------------------------------------------------------------------
module rx_byte_fifo_with_line_read #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] data_in, [14:8] read_count, [15] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // in_tuser: [1:0] opcode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: [7:0] data_out, [14:8] fill_count, [15] cts_pin, [16] overflow,
  //            [23:17] zero
  output logic [23:0] out_tdata,
  // out_tuser: [0] data_valid
  output logic        out_tuser,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  rxbf_pkg::cfg_index_t cfg_index,
  input  logic [6:0]  cfg_data
);
  import rxbf_pkg::*;

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;

  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // Byte store and its registered read port.
  logic [7:0] store [DEPTH];
  logic [7:0] mem_q;

  logic [IW-1:0] read_index_r, read_index_nxt;
  logic [IW-1:0] write_index_r, write_index_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic          rts_r, rts_nxt;
  state_t        state_r, state_nxt;
  opcode_t       op_r, op_nxt;
  logic [6:0]    rem_r, rem_nxt;

  logic          flow_en_r;
  logic [6:0]    thr_r;
  logic          cts_inv_r;

  logic          out_valid_r, out_valid_nxt;
  result_t       res_r, res_nxt;

  logic          wr_en;
  logic          out_free;
  logic          in_acc;

  opcode_t       in_op;
  logic [7:0]    in_byte;
  logic [6:0]    in_count;

  assign in_op    = opcode_t'(in_tuser);
  assign in_byte  = in_tdata[7:0];
  assign in_count = in_tdata[14:8];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + IW'(1);
  endfunction

  always_comb begin
    logic [CW-1:0]   held_new;
    logic [CMPW-1:0] held_x;
    logic [CMPW-1:0] thr_x;
    logic [6:0]      cnt_eff;
    logic            is_ctl;
    logic            done;
    logic            rts_new;

    read_index_nxt  = read_index_r;
    write_index_nxt = write_index_r;
    held_nxt        = held_r;
    rts_nxt         = rts_r;
    state_nxt       = state_r;
    op_nxt          = op_r;
    rem_nxt         = rem_r;
    res_nxt         = res_r;
    wr_en           = 1'b0;
    out_valid_nxt   = out_valid_r && !out_tready;

    held_new = held_r;
    thr_x    = CMPW'(thr_r);
    held_x   = CMPW'(held_r);
    is_ctl   = 1'b0;
    done     = 1'b0;
    rts_new  = rts_r;
    cnt_eff  = (in_op == OP_LINE) ? MAX_READ
             : ((in_count > MAX_READ) ? MAX_READ : in_count);

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_valid_nxt   = 1'b1;
          res_nxt         = '0;
          res_nxt.last    = 1'b1;
          case (in_op)
            OP_PUSH: begin
              if (held_r == FULL_CNT) begin
                res_nxt.overflow = 1'b1;
              end else begin
                wr_en           = 1'b1;
                write_index_nxt = inc_idx(write_index_r);
                held_new        = held_r + CW'(1);
              end
              held_x = CMPW'(held_new);
              if (flow_en_r && (held_x > thr_x)) begin
                rts_new = 1'b0;
              end
              held_nxt           = held_new;
              rts_nxt            = rts_new;
              res_nxt.fill_count = held_x[6:0];
              res_nxt.cts_pin    = rts_new ^ cts_inv_r;
            end
            OP_FLUSH: begin
              read_index_nxt     = write_index_r;
              held_nxt           = '0;
              res_nxt.fill_count = '0;
              res_nxt.cts_pin    = rts_r ^ cts_inv_r;
            end
            default: begin
              if ((held_r == '0) || (cnt_eff == '0)) begin
                if (flow_en_r && (held_x < thr_x)) begin
                  rts_new = 1'b1;
                end
                rts_nxt            = rts_new;
                res_nxt.fill_count = held_x[6:0];
                res_nxt.cts_pin    = rts_new ^ cts_inv_r;
              end else begin
                // The result for a read comes from the drain state.
                out_valid_nxt = out_valid_r && !out_tready;
                res_nxt       = res_r;
                op_nxt        = in_op;
                rem_nxt       = cnt_eff;
                state_nxt     = ST_READ;
              end
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          held_new       = held_r - CW'(1);
          held_x         = CMPW'(held_new);
          is_ctl         = (mem_q == CHAR_CR) || (mem_q == CHAR_LF);
          done           = (rem_r == 7'd1) || (held_new == '0)
                         || ((op_r == OP_LINE) && (mem_q == CHAR_CR));
          if (done && flow_en_r && (held_x < thr_x)) begin
            rts_new = 1'b1;
          end
          held_nxt           = held_new;
          read_index_nxt     = inc_idx(read_index_r);
          rem_nxt            = rem_r - 7'd1;
          rts_nxt            = rts_new;
          out_valid_nxt      = 1'b1;
          res_nxt.data_out   = mem_q;
          res_nxt.data_valid = (op_r == OP_LINE) ? !is_ctl : 1'b1;
          res_nxt.last       = done;
          res_nxt.fill_count = held_x[6:0];
          // Only the final item of a read shows the updated pin level.
          res_nxt.cts_pin    = rts_new ^ cts_inv_r;
          res_nxt.overflow   = 1'b0;
          if (done) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The read port always fetches the entry at the next read index, so the
  // head byte is ready in mem_q. A write to that same entry is forwarded.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[write_index_r] <= in_byte;
    end
    if (wr_en && (write_index_r == read_index_nxt)) begin
      mem_q <= in_byte;
    end else begin
      mem_q <= store[read_index_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_index_r  <= '0;
      write_index_r <= '0;
      held_r        <= '0;
      rts_r         <= 1'b1;
      state_r       <= ST_IDLE;
      op_r          <= OP_PUSH;
      rem_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      read_index_r  <= read_index_nxt;
      write_index_r <= write_index_nxt;
      held_r        <= held_nxt;
      rts_r         <= rts_nxt;
      state_r       <= state_nxt;
      op_r          <= op_nxt;
      rem_r         <= rem_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flow_en_r <= 1'b1;
      thr_r     <= FILL_THRESHOLD_RESET;
      cts_inv_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FLOW_ENABLE:    flow_en_r <= cfg_data[0];
        CFG_FILL_THRESHOLD: thr_r     <= cfg_data;
        CFG_CTS_INVERTED:   cts_inv_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r.overflow, res_r.cts_pin, res_r.fill_count,
                       res_r.data_out};
  assign out_tuser  = res_r.data_valid;
  assign out_tlast  = res_r.last;

endmodule
